/* rtl/linear_frame_request_planner_assert.svh */
// assertion macros for the linear frame request planner
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef LINEAR_FRAME_REQUEST_PLANNER_ASSERT_SVH
`define LINEAR_FRAME_REQUEST_PLANNER_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define LFRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define LFRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LFRP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/lfrp_pkg.sv */
// shared types and constants of the linear frame request planner
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lfrp_pkg;

  localparam int unsigned FrameBits  = 24;
  localparam int unsigned CountBits  = FrameBits - 1;
  localparam int unsigned CalcBits   = FrameBits + 1;
  localparam int unsigned DepthBits  = 7;
  localparam int unsigned SlotBits   = 6;
  localparam int unsigned DivBits    = 24;
  localparam int unsigned ModCntBits = $clog2(DivBits);
  localparam int unsigned CfgIdxBits = 3;

  localparam logic [DepthBits-1:0]        WindowMax = 7'd64;
  localparam logic signed [FrameBits-1:0] PrevReset = -24'sd2098;

  localparam logic [CountBits-1:0] TotalFramesRst = 23'd1;
  localparam logic [CountBits-1:0] RangeLimitRst  = 23'd50;
  localparam logic [DepthBits-1:0] CacheDepthRst  = 7'd10;
  localparam logic [CountBits-1:0] LeadInRst      = 23'd5;
  localparam logic                 RequestAllRst  = 1'b0;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_TOTAL_FRAMES = 3'd0,
    CFG_RANGE_LIMIT  = 3'd1,
    CFG_CACHE_DEPTH  = 3'd2,
    CFG_LEAD_IN      = 3'd3,
    CFG_REQUEST_ALL  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CountBits-1:0] total_frames;
    logic [CountBits-1:0] range_limit;
    logic [DepthBits-1:0] cache_depth;
    logic [CountBits-1:0] lead_in;
    logic                 request_all;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DivBits-1:0]   dividend;
    logic [DepthBits-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [SlotBits-1:0] rem;
  } mod_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_CMP,
    ST_DECIDE,
    ST_START,
    ST_COUNT,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_DONE
  } plan_state_e;

endpackage

`default_nettype wire

/* rtl/lfrp_cfg_regs.sv */
// configuration register file of the linear frame request planner
// depends on lfrp_pkg for register indexes, reset values and cfg_t
`timescale 1ns / 1ps
`default_nettype none

module lfrp_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic [lfrp_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  wire logic [lfrp_pkg::CountBits-1:0]      cfg_data_i,
  output lfrp_pkg::cfg_t                           cfg_o,
  output logic                                     depth_wr_o
);

  lfrp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_frames <= lfrp_pkg::TotalFramesRst;
      cfg_q.range_limit  <= lfrp_pkg::RangeLimitRst;
      cfg_q.cache_depth  <= lfrp_pkg::CacheDepthRst;
      cfg_q.lead_in      <= lfrp_pkg::LeadInRst;
      cfg_q.request_all  <= lfrp_pkg::RequestAllRst;
    end else begin
      if (cfg_valid_i) begin
        unique case (lfrp_pkg::cfg_idx_e'(cfg_index_i))
          lfrp_pkg::CFG_TOTAL_FRAMES: cfg_q.total_frames <= cfg_data_i;
          lfrp_pkg::CFG_RANGE_LIMIT:  cfg_q.range_limit  <= cfg_data_i;
          lfrp_pkg::CFG_CACHE_DEPTH:  cfg_q.cache_depth  <= cfg_data_i[lfrp_pkg::DepthBits-1:0];
          lfrp_pkg::CFG_LEAD_IN:      cfg_q.lead_in      <= cfg_data_i;
          lfrp_pkg::CFG_REQUEST_ALL:  cfg_q.request_all  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o      = cfg_q;
  // window state is cleared at the same edge as the depth transfer
  assign depth_wr_o = cfg_valid_i && (cfg_index_i == lfrp_pkg::CFG_CACHE_DEPTH);

endmodule

`default_nettype wire

/* rtl/lfrp_mod_unit.sv */
// serial restoring remainder unit, one dividend bit per cycle
// depends on lfrp_pkg for widths and the request and response structs
`timescale 1ns / 1ps
`default_nettype none

module lfrp_mod_unit (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lfrp_pkg::mod_req_t req_i,
  output lfrp_pkg::mod_rsp_t rsp_o
);

  localparam logic [lfrp_pkg::ModCntBits-1:0] LastStep =
    lfrp_pkg::ModCntBits'(lfrp_pkg::DivBits - 1);

  logic                               busy_q;
  logic                               done_q;
  logic [lfrp_pkg::ModCntBits-1:0]    cnt_q;
  logic [lfrp_pkg::DivBits-1:0]       shift_q;
  logic [lfrp_pkg::DepthBits-1:0]     rem_q;
  logic [lfrp_pkg::DepthBits-1:0]     divisor_q;

  logic [lfrp_pkg::DepthBits:0] trial;
  logic [lfrp_pkg::DepthBits:0] trial_sub;
  logic                         trial_ge;

  always_comb begin
    trial     = {rem_q, shift_q[lfrp_pkg::DivBits-1]};
    trial_ge  = trial >= {1'b0, divisor_q};
    trial_sub = trial_ge ? (trial - {1'b0, divisor_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      shift_q   <= req_i.dividend;
      divisor_q <= req_i.divisor;
      rem_q     <= '0;
    end else if (busy_q) begin
      shift_q <= {shift_q[lfrp_pkg::DivBits-2:0], 1'b0};
      // partial remainder stays below the divisor
      rem_q   <= trial_sub[lfrp_pkg::DepthBits-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[lfrp_pkg::SlotBits-1:0];

endmodule

`default_nettype wire

/* rtl/linear_frame_request_planner.sv */
// flow: clamp, compare, decide and start states, then the done state with cache depth zero; with a window,
// count, remainder start and wait on the 24-step serial remainder unit for the ring slot come before done
// throughput: one request at a time; done waits for a free output register before a new request is taken
// reset: asynchronous active low, loads register defaults and the window state, no sweep
// top level: sequencer, window state and output register; uses lfrp_pkg,
// lfrp_cfg_regs, lfrp_mod_unit and linear_frame_request_planner_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "linear_frame_request_planner_assert.svh"

module linear_frame_request_planner (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [lfrp_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  wire logic [lfrp_pkg::CountBits-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [lfrp_pkg::FrameBits-1:0] wanted_frame_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [lfrp_pkg::CountBits-1:0]           target_frame_o,
  output logic [lfrp_pkg::CountBits-1:0]           fetch_start_o,
  output logic                                     served_from_cache_o,
  output logic                                     window_cleared_o,
  output logic [lfrp_pkg::SlotBits-1:0]            ring_slot_o
);

  localparam int unsigned FB = lfrp_pkg::FrameBits;
  localparam int unsigned CB = lfrp_pkg::CountBits;
  localparam int unsigned AB = lfrp_pkg::CalcBits;
  localparam int unsigned DB = lfrp_pkg::DepthBits;
  localparam int unsigned SB = lfrp_pkg::SlotBits;
  localparam int unsigned VB = lfrp_pkg::DivBits;

  lfrp_pkg::cfg_t     cfg;
  logic               depth_wr;
  lfrp_pkg::mod_req_t mod_req;
  lfrp_pkg::mod_rsp_t mod_rsp;

  lfrp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .depth_wr_o (depth_wr)
  );

  lfrp_mod_unit u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

  lfrp_pkg::plan_state_e state_q, state_d;

  // window state
  logic signed [FB-1:0] last_q;
  logic [DB-1:0]        valid_run_q;
  logic [SB-1:0]        ring_start_q;

  // per-request working registers
  logic signed [FB-1:0] wanted_q;
  logic [CB-1:0]        n_q;
  logic signed [AB-1:0] diff_q;
  logic                 n_le_rl_q;
  logic                 hit_q;
  logic                 cleared_q;
  logic [DB-1:0]        base_valid_q;
  logic [DB-1:0]        back_q;
  logic signed [AB-1:0] op_a_q;
  logic [CB-1:0]        op_b_q;
  logic                 op_sub_q;
  logic [CB-1:0]        start_q;
  logic [VB-1:0]        count_q;
  logic [DB-1:0]        vr_new_q;
  logic [SB-1:0]        slot_q;

  // output register
  logic          out_valid_q;
  logic [CB-1:0] out_target_q;
  logic [CB-1:0] out_start_q;
  logic          out_hit_q;
  logic          out_cleared_q;
  logic [SB-1:0] out_slot_q;

  logic [DB-1:0] depth_eff;
  logic          depth_zero;
  logic [CB-1:0] tf_m1;
  logic [CB-1:0] n_clamp;

  always_comb begin
    depth_eff  = (cfg.cache_depth > lfrp_pkg::WindowMax) ? lfrp_pkg::WindowMax
                                                         : cfg.cache_depth;
    depth_zero = (depth_eff == '0);
    // an empty clip acts as a single frame
    tf_m1      = (cfg.total_frames == '0) ? '0 : (cfg.total_frames - 1'b1);
    if (wanted_q[FB-1]) begin
      n_clamp = '0;
    end else if (wanted_q[CB-1:0] > tf_m1) begin
      n_clamp = tf_m1;
    end else begin
      n_clamp = wanted_q[CB-1:0];
    end
  end

  // decision on the registered difference
  logic                 gt;
  logic                 gap_ok;
  logic [AB-1:0]        back;
  logic                 hit_c;
  logic                 at_reset_last;
  logic signed [AB-1:0] a_last;
  logic signed [AB-1:0] a_n;
  logic signed [AB-1:0] dec_a;
  logic [CB-1:0]        dec_b;
  logic                 dec_sub;
  logic                 dec_cleared;
  logic [DB-1:0]        dec_base;

  always_comb begin
    gt            = !diff_q[AB-1] && (diff_q != '0);
    gap_ok        = diff_q <= $signed({2'b00, cfg.range_limit});
    back          = -diff_q;
    hit_c         = !depth_zero && !gt && (back < AB'(depth_eff))
                    && (back < AB'(valid_run_q));
    at_reset_last = (last_q == lfrp_pkg::PrevReset);
    a_last        = $signed({last_q[FB-1], last_q});
    a_n           = $signed({2'b00, n_q});
    dec_a         = '0;
    dec_b         = '0;
    dec_sub       = 1'b0;
    dec_cleared   = 1'b0;
    dec_base      = '0;
    if (depth_zero) begin
      priority if (gt && gap_ok) begin
        dec_a = a_last;
        dec_b = CB'(1);
      end else if (!gt && n_le_rl_q) begin
        dec_a = '0;
      end else if (cfg.request_all) begin
        if (gt) begin
          dec_a = a_last;
          dec_b = CB'(1);
        end
      end else begin
        dec_a   = a_n;
        dec_b   = cfg.lead_in;
        dec_sub = 1'b1;
      end
    end else if (hit_c) begin
      dec_a = a_n;
    end else begin
      priority if (gt && (gap_ok || cfg.request_all)) begin
        dec_a    = a_last;
        dec_b    = CB'(1);
        dec_base = valid_run_q;
      end else if (!gt && (n_le_rl_q || cfg.request_all)) begin
        dec_a = '0;
      end else begin
        // long jump: window is invalidated and refilled from a lead-in, or from the window depth after reset
        dec_cleared = 1'b1;
        dec_a       = a_n;
        dec_b       = at_reset_last ? CB'(depth_eff) : cfg.lead_in;
        dec_sub     = 1'b1;
      end
    end
  end

  logic signed [AB-1:0] start_sum;
  logic [CB-1:0]        start_c;
  logic [VB-1:0]        count_c;
  logic [VB-1:0]        ring_base;
  logic [VB-1:0]        dividend_c;
  logic [VB-1:0]        vr_sum;
  logic [DB-1:0]        vr_new_c;
  logic [SB-1:0]        slot_c;
  logic [DB-1:0]        depth_m1;

  always_comb begin
    start_sum  = op_sub_q ? (op_a_q - $signed({2'b00, op_b_q}))
                          : (op_a_q + $signed({2'b00, op_b_q}));
    start_c    = start_sum[AB-1] ? '0 : start_sum[CB-1:0];
    count_c    = {1'b0, n_q} - {1'b0, start_q} + VB'(1);
    ring_base  = cleared_q ? '0 : VB'(ring_start_q);
    dividend_c = hit_q ? (VB'(ring_start_q) + VB'(depth_eff) - VB'(1) - VB'(back_q))
                       : (ring_base + count_q);
    vr_sum     = VB'(base_valid_q) + count_q;
    vr_new_c   = (vr_sum >= VB'(depth_eff)) ? depth_eff : vr_sum[DB-1:0];
    depth_m1   = depth_eff - 1'b1;
    // on a miss the slot of the newest frame sits just before the new ring start; on a hit it is the remainder
    if (hit_q) begin
      slot_c = mod_rsp.rem;
    end else if (mod_rsp.rem == '0) begin
      slot_c = depth_m1[SB-1:0];
    end else begin
      slot_c = mod_rsp.rem - 1'b1;
    end
  end

  assign mod_req.start    = (state_q == lfrp_pkg::ST_MOD_GO);
  assign mod_req.dividend = dividend_c;
  assign mod_req.divisor  = depth_eff;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfrp_pkg::ST_IDLE:     if (in_valid_i) state_d = lfrp_pkg::ST_CLAMP;
      lfrp_pkg::ST_CLAMP:    state_d = lfrp_pkg::ST_CMP;
      lfrp_pkg::ST_CMP:      state_d = lfrp_pkg::ST_DECIDE;
      lfrp_pkg::ST_DECIDE:   state_d = lfrp_pkg::ST_START;
      lfrp_pkg::ST_START:    state_d = depth_zero ? lfrp_pkg::ST_DONE : lfrp_pkg::ST_COUNT;
      lfrp_pkg::ST_COUNT:    state_d = lfrp_pkg::ST_MOD_GO;
      lfrp_pkg::ST_MOD_GO:   state_d = lfrp_pkg::ST_MOD_WAIT;
      lfrp_pkg::ST_MOD_WAIT: if (mod_rsp.done) state_d = lfrp_pkg::ST_DONE;
      lfrp_pkg::ST_DONE:     if (out_free) state_d = lfrp_pkg::ST_IDLE;
      default:               state_d = lfrp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfrp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= lfrp_pkg::PrevReset;
      valid_run_q  <= '0;
      ring_start_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (depth_wr) begin
        valid_run_q  <= '0;
        ring_start_q <= '0;
      end else if (state_q == lfrp_pkg::ST_MOD_WAIT && mod_rsp.done && !hit_q) begin
        valid_run_q  <= vr_new_q;
        ring_start_q <= mod_rsp.rem;
      end
      if ((state_q == lfrp_pkg::ST_START && depth_zero)
          || (state_q == lfrp_pkg::ST_MOD_WAIT && mod_rsp.done && !hit_q)) begin
        last_q <= $signed({1'b0, n_q});
      end
      if (state_q == lfrp_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and output payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lfrp_pkg::ST_IDLE:  if (in_valid_i) wanted_q <= wanted_frame_i;
      lfrp_pkg::ST_CLAMP: n_q <= n_clamp;
      lfrp_pkg::ST_CMP: begin
        diff_q    <= $signed({2'b00, n_q}) - $signed({last_q[FB-1], last_q});
        n_le_rl_q <= (n_q <= cfg.range_limit);
      end
      lfrp_pkg::ST_DECIDE: begin
        hit_q        <= hit_c;
        cleared_q    <= dec_cleared;
        base_valid_q <= dec_base;
        back_q       <= back[DB-1:0];
        op_a_q       <= dec_a;
        op_b_q       <= dec_b;
        op_sub_q     <= dec_sub;
        slot_q       <= '0;
      end
      lfrp_pkg::ST_START: start_q <= start_c;
      lfrp_pkg::ST_COUNT: count_q <= count_c;
      lfrp_pkg::ST_MOD_GO: vr_new_q <= vr_new_c;
      lfrp_pkg::ST_MOD_WAIT: if (mod_rsp.done) slot_q <= slot_c;
      lfrp_pkg::ST_DONE: begin
        if (out_free) begin
          out_target_q  <= n_q;
          out_start_q   <= start_q;
          out_hit_q     <= hit_q;
          out_cleared_q <= cleared_q;
          out_slot_q    <= slot_q;
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o         = 1'b1;
  assign in_ready_o          = (state_q == lfrp_pkg::ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign target_frame_o      = out_target_q;
  assign fetch_start_o       = out_start_q;
  assign served_from_cache_o = out_hit_q;
  assign window_cleared_o    = out_cleared_q;
  assign ring_slot_o         = out_slot_q;

  `LFRP_ASSERT(a_ring_start_in_window, depth_zero || (ring_start_q < SB'(depth_eff)) || (depth_eff == DB'(64)), "ring start outside window")
  `LFRP_ASSERT(a_valid_run_bounded, valid_run_q <= depth_eff, "valid run exceeds window depth")
  `LFRP_ASSERT(a_mod_done_when_waiting, !mod_rsp.done || (state_q == lfrp_pkg::ST_MOD_WAIT), "remainder done outside wait state")
  `LFRP_ASSERT_NEXT(a_hit_fetches_nothing, state_q == lfrp_pkg::ST_DONE && out_free && hit_q, fetch_start_o == target_frame_o, "cache hit with a fetch run")

endmodule

`default_nettype wire
